### src/drpu_pkg.sv
// Shared types, constants and tables for the position keeper with undo.
package drpu_pkg;

  localparam int HISTORY_DEPTH_DEF = 128;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 80;
  localparam int POS_W    = 32;
  localparam int DELTA_W  = 24;
  localparam int DIST_W   = 24;
  localparam int ROT_W    = 34;  // CORDIC x/y, 30 fraction bits
  localparam int ANG_W    = 32;  // CORDIC z, 2^-22 degree units
  localparam int PROD_W   = DIST_W + 1 + ROT_W;
  localparam int STEP_W   = PROD_W - 30;

  // Heading constants in 1/64 degree units.
  localparam int HALF_TURN    = 180 * 64;
  localparam int QUARTER_TURN = HALF_TURN / 2;
  localparam int FULL_TURN    = HALF_TURN * 2;

  localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] CMD_CART  = 2'd0;
  localparam logic [1:0] CMD_POLAR = 2'd1;
  localparam logic [1:0] CMD_UNDO  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  typedef struct packed {
    logic load_in;
    logic init_polar;
    logic rot_step;
    logic mul_x;
    logic mul_y;
    logic round_y;
    logic apply;
    logic pop_read;
    logic pop_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] code;
    logic       stack_empty;
    logic       rot_last;
  } dp_stat_t;

  // arctan(2^-i) in 2^-22 degree units, rounded
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd188743680;
      5'd1:  v = 32'sd111421900;
      5'd2:  v = 32'sd58872272;
      5'd3:  v = 32'sd29884485;
      5'd4:  v = 32'sd15000234;
      5'd5:  v = 32'sd7507429;
      5'd6:  v = 32'sd3754631;
      5'd7:  v = 32'sd1877430;
      5'd8:  v = 32'sd938729;
      5'd9:  v = 32'sd469366;
      5'd10: v = 32'sd234683;
      5'd11: v = 32'sd117342;
      5'd12: v = 32'sd58671;
      5'd13: v = 32'sd29335;
      5'd14: v = 32'sd14668;
      5'd15: v = 32'sd7334;
      5'd16: v = 32'sd3667;
      5'd17: v = 32'sd1833;
      5'd18: v = 32'sd917;
      5'd19: v = 32'sd458;
      5'd20: v = 32'sd229;
      5'd21: v = 32'sd115;
      5'd22: v = 32'sd57;
      5'd23: v = 32'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### src/drpu_ctrl.sv
// Command sequencer: steps the datapath through one command word at a time.
module drpu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  drpu_pkg::dp_stat_t stat,
  output drpu_pkg::dp_cmd_t  cmd
);
  import drpu_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DISP  = 4'd1;
  localparam logic [3:0] ST_ROT   = 4'd2;
  localparam logic [3:0] ST_MULX  = 4'd3;
  localparam logic [3:0] ST_MULY  = 4'd4;
  localparam logic [3:0] ST_RNDY  = 4'd5;
  localparam logic [3:0] ST_APPLY = 4'd6;
  localparam logic [3:0] ST_POPRD = 4'd7;
  localparam logic [3:0] ST_POPLD = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0] state, state_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (stat.code)
          CMD_CART:  state_next = ST_APPLY;
          CMD_POLAR: begin
            cmd.init_polar = 1'b1;
            state_next     = ST_ROT;
          end
          CMD_UNDO:  state_next = stat.stack_empty ? ST_DONE : ST_POPRD;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_ROT: begin
        cmd.rot_step = 1'b1;
        if (stat.rot_last) state_next = ST_MULX;
      end
      ST_MULX: begin
        cmd.mul_x  = 1'b1;
        state_next = ST_MULY;
      end
      ST_MULY: begin
        cmd.mul_y  = 1'b1;
        state_next = ST_RNDY;
      end
      ST_RNDY: begin
        cmd.round_y = 1'b1;
        state_next  = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_DONE;
      end
      ST_POPRD: begin
        cmd.pop_read = 1'b1;
        state_next   = ST_POPLD;
      end
      ST_POPLD: begin
        cmd.pop_load = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

### src/drpu_dp.sv
// Datapath: position registers, CORDIC rotator, multiplier, undo stack memory.
module drpu_dp #(
  parameter int HISTORY_DEPTH = drpu_pkg::HISTORY_DEPTH_DEF,
  parameter int CORDIC_STEPS  = drpu_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  drpu_pkg::dp_cmd_t               cmd,
  output drpu_pkg::dp_stat_t              stat,
  input  logic [drpu_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [1:0]                      s_tuser,
  output logic [drpu_pkg::M_DATA_W-1:0]   m_tdata
);
  import drpu_pkg::*;

  localparam int IterW  = $clog2(CORDIC_STEPS);
  localparam int DepthW = $clog2(HISTORY_DEPTH + 1);
  localparam int AddrW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // latched command word
  logic [1:0]  code;
  logic [15:0] speed, duration;
  logic [14:0] heading;

  // polar path
  logic [DIST_W-1:0]        distance;
  logic signed [ROT_W-1:0]  cx, cy;
  logic signed [ANG_W-1:0]  z;
  logic                     flip;
  logic [IterW-1:0]         iter;
  logic signed [PROD_W-1:0] prod;
  logic signed [STEP_W-1:0] step_x, step_y;

  // architectural state
  logic signed [POS_W-1:0]  pos_x, pos_y;
  logic [DepthW-1:0]        depth;
  logic [2*POS_W-1:0]       stack_mem [HISTORY_DEPTH];
  logic [2*POS_W-1:0]       rd_data;
  logic                     done;

  // result word
  logic [POS_W-1:0] out_x, out_y;
  logic             out_done;
  logic [7:0]       out_cnt, cnt8;

  // heading reduction to [-90, 90] degrees
  logic [14:0]             h_wrap;
  logic signed [15:0]      a_red;
  logic                    flip_red;
  logic [32:0]             sd_prod;

  always_comb begin
    h_wrap   = (heading >= 15'(FULL_TURN)) ? heading - 15'(FULL_TURN) : heading;
    flip_red = 1'b0;
    if (h_wrap >= 15'(3 * QUARTER_TURN)) begin
      a_red = $signed({1'b0, h_wrap}) - 16'sd23040;
    end else if (h_wrap > 15'(QUARTER_TURN)) begin
      a_red    = $signed({1'b0, h_wrap}) - 16'sd11520;
      flip_red = 1'b1;
    end else begin
      a_red = $signed({1'b0, h_wrap});
    end
    sd_prod = {1'b0, 32'(speed) * 32'(duration)} + 33'd128;
  end

  // one CORDIC micro-rotation
  logic signed [ROT_W-1:0] xs, ys;
  logic signed [ANG_W-1:0] atan_i;
  assign xs     = cx >>> iter;
  assign ys     = cy >>> iter;
  assign atan_i = atan_entry(5'(iter));

  // shared multiplier, operand sign applied for the far half-plane
  logic signed [ROT_W-1:0]  mul_op;
  logic signed [PROD_W-1:0] prod_rnd;
  assign mul_op   = cmd.mul_x ? (flip ? -cx : cx) : (flip ? -cy : cy);
  assign prod_rnd = prod + PROD_W'(64'sd536870912);

  // saturating position update
  logic signed [POS_W:0]   sum_x, sum_y;
  logic signed [POS_W-1:0] sat_x, sat_y;
  assign sum_x = $signed({pos_x[POS_W-1], pos_x}) + (POS_W+1)'(step_x);
  assign sum_y = $signed({pos_y[POS_W-1], pos_y}) + (POS_W+1)'(step_y);

  always_comb begin
    if (sum_x[POS_W] != sum_x[POS_W-1])
      sat_x = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    else
      sat_x = sum_x[POS_W-1:0];
    if (sum_y[POS_W] != sum_y[POS_W-1])
      sat_y = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    else
      sat_y = sum_y[POS_W-1:0];
  end

  logic             stack_full;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [DepthW-1:0] depth_dec;
  assign stack_full = (depth == DepthW'(HISTORY_DEPTH));
  assign depth_dec  = depth - DepthW'(1);
  assign wr_addr    = depth[AddrW-1:0];
  assign rd_addr    = depth_dec[AddrW-1:0];

  // state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      depth <= '0;
    end else begin
      if (cmd.apply) begin
        pos_x <= sat_x;
        pos_y <= sat_y;
        if (!stack_full) depth <= depth + DepthW'(1);
      end
      if (cmd.pop_read) depth <= depth_dec;
      if (cmd.pop_load) begin
        pos_x <= rd_data[POS_W-1:0];
        pos_y <= rd_data[2*POS_W-1:POS_W];
      end
    end
  end

  // undo stack memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.apply && !stack_full) stack_mem[wr_addr] <= {pos_y, pos_x};
    if (cmd.pop_read) rd_data <= stack_mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      code     <= s_tuser;
      speed    <= s_tdata[63:48];
      duration <= s_tdata[79:64];
      heading  <= s_tdata[94:80];
      step_x   <= STEP_W'($signed(s_tdata[23:0]));
      step_y   <= STEP_W'($signed(s_tdata[47:24]));
      done     <= 1'b0;
    end
    if (cmd.init_polar) begin
      distance <= sd_prod[DIST_W+7:8];
      cx       <= CORDIC_GAIN;
      cy       <= '0;
      z        <= {a_red, 16'b0};
      flip     <= flip_red;
      iter     <= '0;
    end
    if (cmd.rot_step) begin
      if (!z[ANG_W-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        z  <= z - atan_i;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        z  <= z + atan_i;
      end
      iter <= iter + IterW'(1);
    end
    if (cmd.mul_x || cmd.mul_y) prod <= $signed({1'b0, distance}) * mul_op;
    if (cmd.mul_y)   step_x <= prod_rnd[PROD_W-1:30];
    if (cmd.round_y) step_y <= prod_rnd[PROD_W-1:30];
    if (cmd.pop_load) done <= 1'b1;
    if (cmd.out_load) begin
      out_x    <= pos_x;
      out_y    <= pos_y;
      out_done <= done;
      out_cnt  <= cnt8;
    end
  end

  if (DepthW >= 8) begin : g_cnt_wide
    assign cnt8 = depth[7:0];
  end else begin : g_cnt_narrow
    assign cnt8 = {{(8-DepthW){1'b0}}, depth};
  end

  assign stat.code        = code;
  assign stat.stack_empty = (depth == '0);
  assign stat.rot_last    = (iter == IterW'(CORDIC_STEPS - 1));

  assign m_tdata = {7'b0, out_cnt, out_done, out_y, out_x};

endmodule

### src/dead_reckoning_position_undo.sv
// Top level of the dead-reckoning position keeper with undo stack.
// Each input word carries one command: cartesian move, polar move, undo or
// query, and produces exactly one result word with the position after the
// command (signed Q23.8, saturated), an undo success flag and the number of
// saved positions. One command is in work at a time. A polar move passes
// through the CORDIC rotator, which does one micro-rotation per cycle,
// followed by one shared multiplier used for x and then y. The result sits
// in an output register, so the next command is taken while a result still
// waits. The undo stack is a HISTORY_DEPTH-entry memory with a registered
// read; it needs no clearing.
module dead_reckoning_position_undo #(
  parameter int HISTORY_DEPTH = drpu_pkg::HISTORY_DEPTH_DEF,
  parameter int CORDIC_STEPS  = drpu_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // delta_x[23:0], delta_y[47:24], speed[63:48], duration[79:64],
  // heading[94:80], zero pad [95]
  input  logic [drpu_pkg::S_DATA_W-1:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // x_position[31:0], y_position[63:32], undo_done[64], saved_count[72:65],
  // zero pad [79:73]
  output logic [drpu_pkg::M_DATA_W-1:0] m_tdata
);
  import drpu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: one state per datapath step
  drpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: rotator, multiplier, position and stack
  drpu_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .CORDIC_STEPS  (CORDIC_STEPS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

  // a new word is never taken in the cycle after one was accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a command is in work");

  // the stack is only popped when it holds something
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_read |-> !stat.stack_empty)
    else $error("undo stack popped while empty");

  // the rotator only runs while a command is in work
  a_rot_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.rot_step |-> !s_tready)
    else $error("CORDIC step while idle");

endmodule

### sim/tb_top.sv
// Testbench for the position keeper with undo history: stream stimulus, own predictor, checker.
`timescale 1ns / 100ps

module tb_top;
  import drpu_pkg::*;

  // Block configuration under test; the predictor uses the same values.
  localparam int HIST_DEPTH = 128;
  localparam int ROT_STEPS  = 16;

  // Heading in 1/64 degree units.
  localparam int HEADING_QUARTER = 90 * 64;
  localparam int HEADING_HALF    = 180 * 64;
  localparam int HEADING_FULL    = 360 * 64;

  // CORDIC start vector, 30 fraction bits.
  localparam longint ROT_GAIN = 64'sd652032874;

  // Cycles allowed after the last result before the run ends.
  localparam int SETTLE_CYCLES = ROT_STEPS + 24;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               done;
    logic [7:0]         count;
  } pos_report_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  // delta_x[23:0], delta_y[47:24], speed[63:48], duration[79:64],
  // heading[94:80], zero pad [95]
  logic [S_DATA_W-1:0] s_tdata;
  // cmd[1:0]
  logic [1:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  // x_position[31:0], y_position[63:32], undo_done[64], saved_count[72:65],
  // zero pad [79:73]
  logic [M_DATA_W-1:0] m_tdata;

  // Predicted track and undo history.
  logic signed [31:0] track_x;
  logic signed [31:0] track_y;
  logic signed [31:0] hist_x [HIST_DEPTH];
  logic signed [31:0] hist_y [HIST_DEPTH];
  int                 hist_depth;
  longint             rot_angles [24];

  pos_report_t expected_reports [$];
  pos_report_t want;

  bit steady;          // no idling on either side while set
  int mismatches;
  int results_seen;
  int cmd_count [4];
  int full_moves;
  int clamps;

  dead_reckoning_position_undo #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .CORDIC_STEPS (ROT_STEPS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // arctan(2^-i) in 2^-22 degree units
  initial begin
    rot_angles = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
                   3754631, 1877430, 938729, 469366, 234683, 117342,
                   58671, 29335, 14668, 7334, 3667, 1833,
                   917, 458, 229, 115, 57, 29};
  end

  function automatic logic signed [31:0] clamp_coord(input longint sum);
    if (sum > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return 32'(sum);
  endfunction

  // Works out the result word for one accepted command and queues it.
  task automatic advance_track(input logic [1:0] cmd, input logic signed [23:0] dx,
                               input logic signed [23:0] dy, input logic [15:0] spd,
                               input logic [15:0] dur, input logic [14:0] hdg);
    pos_report_t rep;
    longint ox, oy, h, a, cx, cy, z, xs, ys, distance, sx, sy;
    bit flip;
    int i;
    ox = 0;
    oy = 0;
    rep.done = 1'b0;
    if (cmd == CMD_CART) begin
      ox = longint'(dx);
      oy = longint'(dy);
    end else if (cmd == CMD_POLAR) begin
      // fold heading into [-90, 90] degrees, negating the far half-plane
      h = longint'(hdg);
      flip = 1'b0;
      if (h >= HEADING_FULL) h -= HEADING_FULL;
      if (h >= 3 * HEADING_QUARTER) begin
        a = h - HEADING_FULL;
      end else if (h > HEADING_QUARTER) begin
        a = h - HEADING_HALF;
        flip = 1'b1;
      end else begin
        a = h;
      end
      cx = ROT_GAIN;
      cy = 0;
      z = a * 65536;
      for (i = 0; i < ROT_STEPS && i < 24; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (z >= 0) begin
          cx -= ys;
          cy += xs;
          z -= rot_angles[i];
        end else begin
          cx += ys;
          cy -= xs;
          z += rot_angles[i];
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      distance = (longint'(spd) * longint'(dur) + 128) >>> 8;
      ox = (distance * cx + (longint'(1) <<< 29)) >>> 30;
      oy = (distance * cy + (longint'(1) <<< 29)) >>> 30;
    end
    if (cmd == CMD_CART || cmd == CMD_POLAR) begin
      if (hist_depth < HIST_DEPTH) begin
        hist_x[hist_depth] = track_x;
        hist_y[hist_depth] = track_y;
        hist_depth++;
      end else begin
        full_moves++;
      end
      sx = longint'(track_x) + ox;
      sy = longint'(track_y) + oy;
      track_x = clamp_coord(sx);
      track_y = clamp_coord(sy);
      if (longint'(track_x) != sx) clamps++;
      if (longint'(track_y) != sy) clamps++;
    end else if (cmd == CMD_UNDO && hist_depth > 0) begin
      hist_depth--;
      track_x = hist_x[hist_depth];
      track_y = hist_y[hist_depth];
      rep.done = 1'b1;
    end
    rep.x = track_x;
    rep.y = track_y;
    rep.count = 8'(hist_depth);
    expected_reports.push_back(rep);
  endtask

  // Sends one command word; may idle first. Returns right after acceptance
  // with tvalid still high, so back-to-back words need no extra edge.
  task automatic send_command(input logic [1:0] cmd, input logic signed [23:0] dx,
                              input logic signed [23:0] dy, input logic [15:0] spd,
                              input logic [15:0] dur, input logic [14:0] hdg);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {1'b0, 31'($urandom), $urandom, $urandom};
      s_tuser  <= 2'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, hdg, dur, spd, dy, dx};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cmd_count[cmd]++;
    advance_track(cmd, dx, dy, spd, dur, hdg);
  endtask

  // Every field random; unused fields must not matter.
  task automatic send_with_noise(input logic [1:0] cmd);
    send_command(cmd, 24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                 15'($urandom));
  endtask

  // Hold the sender off until every queued result word has come back.
  task automatic wait_for_reports();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint exp_val);
    $display("result %0d: %s got %0d, expected %0d", results_seen, field, got, exp_val);
    mismatches++;
  endtask

  // Result checker: one word per handshake against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected word", longint'(m_tdata[63:0]), 0);
      end else begin
        want = expected_reports.pop_front();
        if ($signed(m_tdata[31:0]) !== want.x)
          report_mismatch("x_position", $signed(m_tdata[31:0]), want.x);
        if ($signed(m_tdata[63:32]) !== want.y)
          report_mismatch("y_position", $signed(m_tdata[63:32]), want.y);
        if (m_tdata[64] !== want.done)
          report_mismatch("undo_done", longint'(m_tdata[64]), longint'(want.done));
        if (m_tdata[72:65] !== want.count)
          report_mismatch("saved_count", longint'(m_tdata[72:65]), longint'(want.count));
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 35);
  end

  // Query and undo straight out of reset: origin, empty history.
  task automatic test_reset_state();
    send_with_noise(CMD_QUERY);
    send_with_noise(CMD_UNDO);
  endtask

  task automatic test_cartesian_extremes();
    send_command(CMD_CART, 24'sh7FFFFF, 24'sh7FFFFF, 16'($urandom), 16'($urandom),
                 15'($urandom));
    send_command(CMD_CART, 24'sh800000, 24'sh800000, 16'($urandom), 16'($urandom),
                 15'($urandom));
    send_command(CMD_CART, 24'sh000000, 24'sh000000, 16'($urandom), 16'($urandom),
                 15'($urandom));
    send_command(CMD_CART, 24'shFFFFFF, 24'sh000001, 16'($urandom), 16'($urandom),
                 15'($urandom));
  endtask

  // Quadrant edges, the wrap of headings past a full turn, distance limits.
  task automatic test_polar_headings();
    int headings [9];
    int i;
    headings = '{0, HEADING_QUARTER, HEADING_QUARTER + 1, HEADING_HALF,
                 3 * HEADING_QUARTER - 1, 3 * HEADING_QUARTER, HEADING_FULL - 1,
                 HEADING_FULL, 32767};
    for (i = 0; i < 9; i++)
      send_command(CMD_POLAR, 24'($urandom), 24'($urandom), 16'hFFFF, 16'hFFFF,
                   15'(headings[i]));
    send_command(CMD_POLAR, 24'($urandom), 24'($urandom), 16'h0000, 16'hFFFF, 15'd1000);
    send_command(CMD_POLAR, 24'($urandom), 24'($urandom), 16'h0001, 16'h0001, 15'd2880);
    send_command(CMD_POLAR, 24'($urandom), 24'($urandom), 16'h0100, 16'h0100, 15'd2880);
  endtask

  task automatic test_undo_query();
    send_with_noise(CMD_UNDO);
    send_with_noise(CMD_UNDO);
    send_with_noise(CMD_QUERY);
  endtask

  // Drive x to the top and y to the bottom of the range while the history
  // fills up and overflows, then unwind it past empty.
  task automatic test_history_overflow();
    int i;
    steady = 1'b1;
    for (i = 0; i < 260; i++) begin
      if (i == 150) steady = 1'b0;
      if ($urandom_range(0, 3) != 0)
        send_command(CMD_CART, 24'sh7FFFFF - 24'($urandom_range(0, 4095)),
                     24'sh800000 + 24'($urandom_range(0, 4095)), 16'($urandom),
                     16'($urandom), 15'($urandom));
      else
        send_command(CMD_POLAR, 24'($urandom), 24'($urandom),
                     16'hFFFF - 16'($urandom_range(0, 255)),
                     16'hFFFF - 16'($urandom_range(0, 255)),
                     15'($urandom_range(3 * HEADING_QUARTER + 1, HEADING_FULL - 1)));
    end
    for (i = 0; i < 132; i++) send_with_noise(CMD_UNDO);
    send_with_noise(CMD_QUERY);
  endtask

  task automatic test_random_mix();
    int i;
    int pick;
    for (i = 0; i < 336; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        send_with_noise(CMD_CART);
      else if (pick < 6)
        send_command(CMD_POLAR, 24'($urandom), 24'($urandom), 16'($urandom),
                     16'($urandom), 15'($urandom_range(0, HEADING_FULL - 1)));
      else if (pick < 7)
        send_with_noise(CMD_POLAR);
      else if (pick < 9)
        send_with_noise(CMD_UNDO);
      else
        send_with_noise(CMD_QUERY);
      if (i == 200) wait_for_reports();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_QUERY;
    m_tready = 1'b0;
    steady = 1'b0;
    track_x = '0;
    track_y = '0;
    hist_depth = 0;
    mismatches = 0;
    results_seen = 0;
    full_moves = 0;
    clamps = 0;
    cmd_count = '{0, 0, 0, 0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_cartesian_extremes();
    test_polar_headings();
    test_undo_query();
    wait_for_reports();
    test_history_overflow();
    wait_for_reports();
    test_random_mix();
    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d cartesian, %0d polar, %0d undo, %0d query words; %0d results checked",
             cmd_count[CMD_CART], cmd_count[CMD_POLAR], cmd_count[CMD_UNDO],
             cmd_count[CMD_QUERY], results_seen);
    $display("moves on a full history: %0d, clamped coordinates: %0d, mismatches: %0d",
             full_moves, clamps, mismatches);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
